### rtl/core/shmd_pkg.sv
// ----------------------------------------------------------------------------
// shmd_pkg
// Shared types and constants for the speed hysteresis motion detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shmd_pkg;

    localparam int unsigned VEL_W    = 16;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned MUL_W    = 17;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
    localparam logic [ACC_W-1:0]    ROUND_HALF = 32'h0000_8000;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT = 17'd13107;
    localparam logic [SPEED_W-1:0]  RST_HIGH   = 16'd640;
    localparam logic [SPEED_W-1:0]  RST_LOW    = 16'd512;
    localparam logic [COUNT_W-1:0]  RST_CEIL   = 8'd60;
    localparam logic [COUNT_W-1:0]  RST_MOVING = 8'd30;

    localparam logic [2:0] REG_WEIGHT  = 3'd0;
    localparam logic [2:0] REG_HIGH    = 3'd1;
    localparam logic [2:0] REG_LOW     = 3'd2;
    localparam logic [2:0] REG_CEILING = 3'd3;
    localparam logic [2:0] REG_MOVING  = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

`default_nettype wire

### rtl/core/shmd_isqrt.sv
// ----------------------------------------------------------------------------
// shmd_isqrt
// Iterative floored square root of a 32-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shmd_isqrt
    import shmd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [ACC_W-1:0]    i_radicand,
    output      t_sqrt_stat          o_stat,
    output      logic [SPEED_W-1:0]  o_root
);

    logic [ACC_W-1:0]   r_rad;
    logic [17:0]        r_rem;
    logic [SPEED_W-1:0] r_root;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [17:0] w_rem_sh;
    logic [17:0] w_trial;
    logic        w_fit;

    assign w_rem_sh = {r_rem[15:0], r_rad[ACC_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[ACC_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[SPEED_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[SPEED_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("square root restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a finished run");
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cnt == 4'd0)
        else $error("done before sixteen iterations");
`endif

endmodule

`default_nettype wire

### rtl/core/speed_hysteresis_motion_detector.sv
// ----------------------------------------------------------------------------
// speed_hysteresis_motion_detector
// Speed magnitude, low-pass smoothing and hysteresis motion flag.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. An item goes from acceptance to a valid
// result in these steps: S_SQN and S_SQE square and sum the velocities, the
// square-root unit runs 16 iterations and its root is picked up, two filter
// passes go through the single 17x17 multiplier-accumulator, and S_DONE
// registers the result. The input stalls while an item is in work, so a new
// beat is accepted only once the previous item is through.
// The result sits in an output register, so a stalled output only delays the
// final update of the following item. Register writes go through APB at
// byte offsets 0x00 (weight), 0x04 (high), 0x08 (low), 0x0C (ceiling) and
// 0x10 (moving level); write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module speed_hysteresis_motion_detector
    import shmd_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_in_valid,
    output      logic                       o_in_stall,
    input  wire logic signed [VEL_W-1:0]    i_vel_north,
    input  wire logic signed [VEL_W-1:0]    i_vel_east,

    output      logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    output      logic [SPEED_W-1:0]         o_speed_now,
    output      logic [SPEED_W-1:0]         o_speed_smoothed,
    output      logic                       o_moving,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [DATA_W-1:0]          pwdata,
    output      logic [DATA_W-1:0]          prdata,
    output      logic                       pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQN,
        S_SQE,
        S_SQRT,
        S_FLA,
        S_FLB,
        S_DONE
    } t_state;

    t_state r_state;

    logic [WEIGHT_W-1:0] r_weight;
    logic [SPEED_W-1:0]  r_high;
    logic [SPEED_W-1:0]  r_low;
    logic [COUNT_W-1:0]  r_ceil;
    logic [COUNT_W-1:0]  r_mlevel;

    logic [SPEED_W-1:0]  r_filt;
    logic [COUNT_W-1:0]  r_count;

    logic [VEL_W-1:0]    r_an;
    logic [VEL_W-1:0]    r_ae;
    logic [SPEED_W-1:0]  r_speed;
    logic [ACC_W-1:0]    r_acc;

    logic                r_out_valid;
    logic [SPEED_W-1:0]  r_out_speed;
    logic [SPEED_W-1:0]  r_out_filt;
    logic                r_out_moving;

    logic                w_cfg_wr;
    logic [2:0]          w_idx;
    logic [WEIGHT_W-1:0] w_wclamp;
    logic [MUL_W-1:0]    w_mul_a;
    logic [MUL_W-1:0]    w_mul_b;
    logic [2*MUL_W-1:0]  w_prod;
    logic                w_take;
    logic                w_slot_free;
    logic [SPEED_W-1:0]  n_filt;
    logic [COUNT_W:0]    w_up;
    logic [COUNT_W-1:0]  n_count;
    logic                w_sq_start;
    t_sqrt_stat          w_sq_stat;
    logic [SPEED_W-1:0]  w_sq_root;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= RST_WEIGHT;
            r_high   <= RST_HIGH;
            r_low    <= RST_LOW;
            r_ceil   <= RST_CEIL;
            r_mlevel <= RST_MOVING;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_WEIGHT:  r_weight <= pwdata[WEIGHT_W-1:0];
                REG_HIGH:    r_high   <= pwdata[SPEED_W-1:0];
                REG_LOW:     r_low    <= pwdata[SPEED_W-1:0];
                REG_CEILING: r_ceil   <= pwdata[COUNT_W-1:0];
                REG_MOVING:  r_mlevel <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WEIGHT:  prdata = {{(DATA_W-WEIGHT_W){1'b0}}, r_weight};
            REG_HIGH:    prdata = {{(DATA_W-SPEED_W){1'b0}}, r_high};
            REG_LOW:     prdata = {{(DATA_W-SPEED_W){1'b0}}, r_low};
            REG_CEILING: prdata = {{(DATA_W-COUNT_W){1'b0}}, r_ceil};
            REG_MOVING:  prdata = {{(DATA_W-COUNT_W){1'b0}}, r_mlevel};
            default:     prdata = '0;
        endcase
    end

    // ---------------- shared multiplier-accumulator ----------------
    assign w_wclamp = r_weight[WEIGHT_W-1] ? WEIGHT_ONE : r_weight;

    always_comb begin
        case (r_state)
            S_SQN: begin
                w_mul_a = {1'b0, r_an};
                w_mul_b = {1'b0, r_an};
            end
            S_SQE: begin
                w_mul_a = {1'b0, r_ae};
                w_mul_b = {1'b0, r_ae};
            end
            S_FLA: begin
                w_mul_a = w_wclamp;
                w_mul_b = {1'b0, r_speed};
            end
            S_FLB: begin
                w_mul_a = WEIGHT_ONE - w_wclamp;
                w_mul_b = {1'b0, r_filt};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // ---------------- square root ----------------
    assign w_sq_start = (r_state == S_SQE);

    shmd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_acc + w_prod[ACC_W-1:0]),
        .o_stat     (w_sq_stat),
        .o_root     (w_sq_root)
    );

    // ---------------- filter and hysteresis counter ----------------
    assign n_filt = r_acc[ACC_W-1 -: SPEED_W];
    assign w_up   = {1'b0, r_count} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_count = r_count;
        if (n_filt > r_high) begin
            n_count = (w_up < {1'b0, r_ceil}) ? w_up[COUNT_W-1:0] : r_ceil;
        end else if (n_filt < r_low) begin
            if (r_count != '0) begin
                n_count = r_count - {{(COUNT_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // ---------------- sequencer ----------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_take      = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_filt      <= '0;
            r_count     <= '0;
        end else begin
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= S_SQN;
                    end
                end
                S_SQN:  r_state <= S_SQE;
                S_SQE:  r_state <= S_SQRT;
                S_SQRT: begin
                    if (w_sq_stat.done) begin
                        r_state <= S_FLA;
                    end
                end
                S_FLA:  r_state <= S_FLB;
                S_FLB:  r_state <= S_DONE;
                S_DONE: begin
                    if (w_slot_free) begin
                        r_filt       <= n_filt;
                        r_count      <= n_count;
                        r_out_speed  <= r_speed;
                        r_out_filt   <= n_filt;
                        r_out_moving <= (n_count > r_mlevel);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_an <= i_vel_north[VEL_W-1] ? (~i_vel_north + 1'b1) : i_vel_north;
            r_ae <= i_vel_east[VEL_W-1]  ? (~i_vel_east + 1'b1)  : i_vel_east;
        end
        unique case (r_state)
            S_SQN:   r_acc <= w_prod[ACC_W-1:0];
            S_SQE:   r_acc <= r_acc + w_prod[ACC_W-1:0];
            S_FLA:   r_acc <= w_prod[ACC_W-1:0] + ROUND_HALF;
            S_FLB:   r_acc <= r_acc + w_prod[ACC_W-1:0];
            default: ;
        endcase
        if (r_state == S_SQRT && w_sq_stat.done) begin
            r_speed <= w_sq_root;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_now      = r_out_speed;
    assign o_speed_smoothed = r_out_filt;
    assign o_moving         = r_out_moving;

`ifndef NO_ASSERTIONS
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_state == S_SQN)
        else $error("accepted beat did not start the sequence");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final step");
    a_sqrt_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQRT |-> w_sq_stat.busy || w_sq_stat.done)
        else $error("waiting on an idle square-root unit");
    a_done_only_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_stat.done |-> r_state == S_SQRT)
        else $error("square root finished out of sequence");
`endif

endmodule

`default_nettype wire
